### src/brf_pkg.sv
// brf_pkg: shared types, codes and saturating fixed-point helpers for the
// brent root finder. No dependencies; used by brf_muldiv and brent_root_finder.
package brf_pkg;

    localparam int FRAC_BITS_DEF = 32;

    localparam logic       OP_START = 1'b0;
    localparam logic       OP_VALUE = 1'b1;

    localparam logic [2:0] OUT_EVAL   = 3'd0;
    localparam logic [2:0] OUT_FOUND  = 3'd1;
    localparam logic [2:0] OUT_NOCONV = 3'd2;
    localparam logic [2:0] OUT_BADARG = 3'd3;
    localparam logic [2:0] OUT_UNEXP  = 3'd4;

    localparam logic [1:0] CFG_TOLERANCE  = 2'd0;
    localparam logic [1:0] CFG_ITER_LIMIT = 2'd1;
    localparam logic [1:0] CFG_REL_EPS    = 2'd2;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    typedef struct packed {
        logic start;
        logic div;
    } md_req_t;

    typedef struct packed {
        logic done;
    } md_rsp_t;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                   input logic signed [63:0] y);
        logic signed [64:0] s;
        s = {x[63], x} + {y[63], y};
        if (s[64] != s[63])
            return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] x,
                                                   input logic signed [63:0] y);
        logic signed [64:0] s;
        s = {x[63], x} - {y[63], y};
        if (s[64] != s[63])
            return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_neg(input logic signed [63:0] x);
        return (x == S64_MIN) ? S64_MAX : -x;
    endfunction

    function automatic logic signed [63:0] sat_abs(input logic signed [63:0] x);
        return x[63] ? sat_neg(x) : x;
    endfunction

    // halve, truncating toward zero
    function automatic logic signed [63:0] half(input logic signed [63:0] x);
        logic signed [63:0] t;
        t = x + {63'd0, x[63]};
        return t >>> 1;
    endfunction

    function automatic logic opposite(input logic signed [63:0] x,
                                      input logic signed [63:0] y);
        return (x > 0 && y < 0) || (x < 0 && y > 0);
    endfunction

endpackage

### src/brent_root_finder.sv
// brent_root_finder: top level, sequencer for brent's method over one shared
// multiply / divide unit. Depends on brf_pkg and brf_muldiv.
//
//   port group   direction  handshake           payload
//   cfg          in         cfg_write           cfg_index, cfg_data
//   in           in         in_valid/in_ready   opcode, left_end, right_end,
//                                               func_value, value_invalid
//   out          out        out_valid/out_ready outcome, point
//
// a full brent step runs its products and quotients one at a time on the
// serial unit, up to 4 divides and 10 multiplies a step.
// in_ready is high only while the sequencer is idle; one word at a time.
// a finished word sits in the output register while the next word is taken.
// reset restores the register defaults and drops any search in progress.
module brent_root_finder #(
    parameter int FRAC_BITS = brf_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [62:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                opcode,
    input  logic signed [63:0]  left_end,
    input  logic signed [63:0]  right_end,
    input  logic signed [63:0]  func_value,
    input  logic                value_invalid,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          outcome,
    output logic signed [63:0]  point
);
    import brf_pkg::*;

    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    typedef enum logic [1:0] {PH_IDLE, PH_WAIT_FA, PH_WAIT_FB, PH_ITER} phase_t;

    typedef enum logic [4:0] {
        S_IDLE, S_B0, S_B1, S_B2, S_B3, S_B4, S_B5, S_SEC,
        S_G1, S_G2, S_G3, S_G4, S_G5, S_G6, S_G7, S_G8,
        S_J0, S_J1, S_J2, S_J3, S_J4, S_FIN, S_WAIT, S_EMIT
    } state_t;

    state_t             state_reg;
    state_t             ret_reg;
    phase_t             phase_reg;

    logic [62:0]        tol_reg;
    logic [15:0]        iter_limit_reg;
    logic [31:0]        rel_eps_reg;

    logic signed [63:0] pa_reg, pb_reg, pc_reg;
    logic signed [63:0] fa_reg, fb_reg, fc_reg;
    logic signed [63:0] d_reg, e_reg;
    logic [15:0]        iter_reg;

    logic signed [63:0] tol1_reg, xm_reg, xm2_reg;
    logic signed [63:0] s_reg, p_reg, q_reg, qq_reg, r_reg, rm1_reg, t1_reg, acc_reg;

    logic [2:0]         res_code_reg;
    logic signed [63:0] res_point_reg;
    logic               out_valid_reg;
    logic [2:0]         outcome_reg;
    logic signed [63:0] point_reg;

    logic               md_start_reg;
    logic               md_div_reg;
    logic signed [63:0] md_a_reg, md_b_reg;

    md_req_t            md_req;
    md_rsp_t            md_rsp;
    logic signed [63:0] md_result;

    logic [15:0]        iter_inc;
    logic signed [63:0] abs_pb;
    logic signed [63:0] q_adj;
    logic signed [63:0] min2;
    logic signed [63:0] min_lim;
    logic signed [63:0] fin_step;

    assign md_req.start = md_start_reg;
    assign md_req.div   = md_div_reg;

    brf_muldiv #(
        .FRAC_BITS(FRAC_BITS)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req),
        .op_a   (md_a_reg),
        .op_b   (md_b_reg),
        .rsp    (md_rsp),
        .result (md_result)
    );

    assign iter_inc = iter_reg + 16'd1;
    assign abs_pb   = sat_abs(pb_reg);
    assign q_adj    = (p_reg > 0) ? sat_neg(q_reg) : q_reg;
    assign min2     = sat_abs(acc_reg);
    assign min_lim  = (t1_reg < min2) ? t1_reg : min2;
    assign fin_step = (sat_abs(d_reg) > tol1_reg) ? d_reg
                    : ((xm_reg > 0) ? tol1_reg : sat_neg(tol1_reg));

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign outcome   = outcome_reg;
    assign point     = point_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            phase_reg      <= PH_IDLE;
            tol_reg        <= 63'd4295;
            iter_limit_reg <= 16'd100;
            rel_eps_reg    <= 32'd0;
            pa_reg         <= '0;
            pb_reg         <= '0;
            pc_reg         <= '0;
            fa_reg         <= '0;
            fb_reg         <= '0;
            fc_reg         <= '0;
            d_reg          <= '0;
            e_reg          <= '0;
            iter_reg       <= '0;
            out_valid_reg  <= 1'b0;
            md_start_reg   <= 1'b0;
            md_div_reg     <= 1'b0;
        end
        else
        begin
            md_start_reg <= 1'b0;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_TOLERANCE:  tol_reg        <= cfg_data;
                    CFG_ITER_LIMIT: iter_limit_reg <= cfg_data[15:0];
                    CFG_REL_EPS:    rel_eps_reg    <= cfg_data[31:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_EMIT;
                        res_point_reg <= '0;
                        if (opcode == OP_START)
                        begin
                            if (tol_reg == 63'd0 || iter_limit_reg == 16'd0)
                            begin
                                res_code_reg <= OUT_BADARG;
                                phase_reg    <= PH_IDLE;
                            end
                            else
                            begin
                                pa_reg        <= left_end;
                                pb_reg        <= right_end;
                                iter_reg      <= '0;
                                phase_reg     <= PH_WAIT_FA;
                                res_code_reg  <= OUT_EVAL;
                                res_point_reg <= left_end;
                            end
                        end
                        else if (phase_reg == PH_IDLE)
                        begin
                            res_code_reg <= OUT_UNEXP;
                        end
                        else if (value_invalid)
                        begin
                            res_code_reg <= OUT_NOCONV;
                            phase_reg    <= PH_IDLE;
                        end
                        else if (phase_reg == PH_WAIT_FA)
                        begin
                            fa_reg        <= func_value;
                            phase_reg     <= PH_WAIT_FB;
                            res_code_reg  <= OUT_EVAL;
                            res_point_reg <= pb_reg;
                        end
                        else if (phase_reg == PH_WAIT_FB)
                        begin
                            fb_reg <= func_value;
                            if (fa_reg == 0)
                            begin
                                res_code_reg  <= OUT_FOUND;
                                res_point_reg <= pa_reg;
                                phase_reg     <= PH_IDLE;
                            end
                            else if (func_value == 0)
                            begin
                                res_code_reg  <= OUT_FOUND;
                                res_point_reg <= pb_reg;
                                phase_reg     <= PH_IDLE;
                            end
                            else if (!opposite(fa_reg, func_value))
                            begin
                                res_code_reg <= OUT_NOCONV;
                                phase_reg    <= PH_IDLE;
                            end
                            else
                            begin
                                pc_reg    <= pa_reg;
                                fc_reg    <= fa_reg;
                                d_reg     <= sat_sub(pb_reg, pa_reg);
                                e_reg     <= sat_sub(pb_reg, pa_reg);
                                iter_reg  <= '0;
                                state_reg <= S_B0;
                            end
                        end
                        else
                        begin
                            fb_reg   <= func_value;
                            iter_reg <= iter_inc;
                            if (iter_inc >= iter_limit_reg || iter_inc == 16'd0)
                            begin
                                res_code_reg <= OUT_NOCONV;
                                phase_reg    <= PH_IDLE;
                            end
                            else
                            begin
                                state_reg <= S_B0;
                            end
                        end
                    end
                end

                S_B0:
                begin
                    if (!opposite(fb_reg, fc_reg))
                    begin
                        pc_reg <= pa_reg;
                        fc_reg <= fa_reg;
                        d_reg  <= sat_sub(pb_reg, pa_reg);
                        e_reg  <= sat_sub(pb_reg, pa_reg);
                    end
                    state_reg <= S_B1;
                end

                S_B1:
                begin
                    // keep b as the best estimate
                    if (sat_abs(fc_reg) < sat_abs(fb_reg))
                    begin
                        pa_reg <= pb_reg;
                        pb_reg <= pc_reg;
                        pc_reg <= pb_reg;
                        fa_reg <= fb_reg;
                        fb_reg <= fc_reg;
                        fc_reg <= fb_reg;
                    end
                    state_reg <= S_B2;
                end

                S_B2:
                begin
                    md_start_reg <= 1'b1;
                    md_div_reg   <= 1'b0;
                    md_a_reg     <= {32'd0, rel_eps_reg};
                    md_b_reg     <= sat_add(abs_pb, abs_pb);
                    ret_reg      <= S_B3;
                    state_reg    <= S_WAIT;
                end

                S_B3:
                begin
                    tol1_reg  <= sat_add(acc_reg, {2'b00, tol_reg[62:1]});
                    xm_reg    <= half(sat_sub(pc_reg, pb_reg));
                    state_reg <= S_B4;
                end

                S_B4:
                begin
                    xm2_reg <= sat_add(xm_reg, xm_reg);
                    if (sat_abs(xm_reg) <= tol1_reg || fb_reg == 0)
                    begin
                        res_code_reg  <= OUT_FOUND;
                        res_point_reg <= pb_reg;
                        phase_reg     <= PH_IDLE;
                        state_reg     <= S_EMIT;
                    end
                    else if (sat_abs(e_reg) >= tol1_reg && sat_abs(fa_reg) > sat_abs(fb_reg))
                    begin
                        md_start_reg <= 1'b1;
                        md_div_reg   <= 1'b1;
                        md_a_reg     <= fb_reg;
                        md_b_reg     <= fa_reg;
                        ret_reg      <= S_B5;
                        state_reg    <= S_WAIT;
                    end
                    else
                    begin
                        d_reg     <= xm_reg;
                        e_reg     <= xm_reg;
                        state_reg <= S_FIN;
                    end
                end

                S_B5:
                begin
                    s_reg        <= acc_reg;
                    md_start_reg <= 1'b1;
                    state_reg    <= S_WAIT;
                    if (pa_reg == pc_reg)
                    begin
                        // secant step
                        md_div_reg <= 1'b0;
                        md_a_reg   <= xm2_reg;
                        md_b_reg   <= acc_reg;
                        ret_reg    <= S_SEC;
                    end
                    else
                    begin
                        md_div_reg <= 1'b1;
                        md_a_reg   <= fa_reg;
                        md_b_reg   <= fc_reg;
                        ret_reg    <= S_G1;
                    end
                end

                S_SEC:
                begin
                    p_reg     <= acc_reg;
                    q_reg     <= sat_sub(ONE, s_reg);
                    state_reg <= S_J0;
                end

                S_G1:
                begin
                    qq_reg       <= acc_reg;
                    md_start_reg <= 1'b1;
                    md_div_reg   <= 1'b1;
                    md_a_reg     <= fb_reg;
                    md_b_reg     <= fc_reg;
                    ret_reg      <= S_G2;
                    state_reg    <= S_WAIT;
                end

                S_G2:
                begin
                    r_reg        <= acc_reg;
                    rm1_reg      <= sat_sub(acc_reg, ONE);
                    md_start_reg <= 1'b1;
                    md_div_reg   <= 1'b0;
                    md_a_reg     <= xm2_reg;
                    md_b_reg     <= qq_reg;
                    ret_reg      <= S_G3;
                    state_reg    <= S_WAIT;
                end

                S_G3:
                begin
                    md_start_reg <= 1'b1;
                    md_div_reg   <= 1'b0;
                    md_a_reg     <= acc_reg;
                    md_b_reg     <= sat_sub(qq_reg, r_reg);
                    ret_reg      <= S_G4;
                    state_reg    <= S_WAIT;
                end

                S_G4:
                begin
                    t1_reg       <= acc_reg;
                    md_start_reg <= 1'b1;
                    md_div_reg   <= 1'b0;
                    md_a_reg     <= sat_sub(pb_reg, pa_reg);
                    md_b_reg     <= rm1_reg;
                    ret_reg      <= S_G5;
                    state_reg    <= S_WAIT;
                end

                S_G5:
                begin
                    md_start_reg <= 1'b1;
                    md_div_reg   <= 1'b0;
                    md_a_reg     <= s_reg;
                    md_b_reg     <= sat_sub(t1_reg, acc_reg);
                    ret_reg      <= S_G6;
                    state_reg    <= S_WAIT;
                end

                S_G6:
                begin
                    p_reg        <= acc_reg;
                    md_start_reg <= 1'b1;
                    md_div_reg   <= 1'b0;
                    md_a_reg     <= sat_sub(qq_reg, ONE);
                    md_b_reg     <= rm1_reg;
                    ret_reg      <= S_G7;
                    state_reg    <= S_WAIT;
                end

                S_G7:
                begin
                    md_start_reg <= 1'b1;
                    md_div_reg   <= 1'b0;
                    md_a_reg     <= acc_reg;
                    md_b_reg     <= sat_sub(s_reg, ONE);
                    ret_reg      <= S_G8;
                    state_reg    <= S_WAIT;
                end

                S_G8:
                begin
                    q_reg     <= acc_reg;
                    state_reg <= S_J0;
                end

                S_J0:
                begin
                    q_reg        <= q_adj;
                    p_reg        <= sat_abs(p_reg);
                    md_start_reg <= 1'b1;
                    md_div_reg   <= 1'b0;
                    md_a_reg     <= sat_add(xm2_reg, xm_reg);
                    md_b_reg     <= q_adj;
                    ret_reg      <= S_J1;
                    state_reg    <= S_WAIT;
                end

                S_J1:
                begin
                    t1_reg       <= acc_reg;
                    md_start_reg <= 1'b1;
                    md_div_reg   <= 1'b0;
                    md_a_reg     <= tol1_reg;
                    md_b_reg     <= q_reg;
                    ret_reg      <= S_J2;
                    state_reg    <= S_WAIT;
                end

                S_J2:
                begin
                    t1_reg       <= sat_sub(t1_reg, sat_abs(acc_reg));
                    md_start_reg <= 1'b1;
                    md_div_reg   <= 1'b0;
                    md_a_reg     <= e_reg;
                    md_b_reg     <= q_reg;
                    ret_reg      <= S_J3;
                    state_reg    <= S_WAIT;
                end

                S_J3:
                begin
                    // accept interpolation only if it stays well inside the bracket
                    if (sat_add(p_reg, p_reg) < min_lim)
                    begin
                        e_reg        <= d_reg;
                        md_start_reg <= 1'b1;
                        md_div_reg   <= 1'b1;
                        md_a_reg     <= p_reg;
                        md_b_reg     <= q_reg;
                        ret_reg      <= S_J4;
                        state_reg    <= S_WAIT;
                    end
                    else
                    begin
                        d_reg     <= xm_reg;
                        e_reg     <= xm_reg;
                        state_reg <= S_FIN;
                    end
                end

                S_J4:
                begin
                    d_reg     <= acc_reg;
                    state_reg <= S_FIN;
                end

                S_FIN:
                begin
                    pa_reg        <= pb_reg;
                    fa_reg        <= fb_reg;
                    pb_reg        <= sat_add(pb_reg, fin_step);
                    phase_reg     <= PH_ITER;
                    res_code_reg  <= OUT_EVAL;
                    res_point_reg <= sat_add(pb_reg, fin_step);
                    state_reg     <= S_EMIT;
                end

                S_WAIT:
                begin
                    if (md_rsp.done)
                    begin
                        acc_reg   <= md_result;
                        state_reg <= ret_reg;
                    end
                end

                S_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        outcome_reg   <= res_code_reg;
                        point_reg     <= res_point_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### src/brf_muldiv.sv
// brf_muldiv: shared bit-serial fixed-point multiply / divide unit.
// Depends on brf_pkg; magnitudes, truncation toward zero, symmetric saturation.
module brf_muldiv #(
    parameter int FRAC_BITS = brf_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  brf_pkg::md_req_t       req,
    input  logic signed [63:0]     op_a,
    input  logic signed [63:0]     op_b,
    output brf_pkg::md_rsp_t       rsp,
    output logic signed [63:0]     result
);
    import brf_pkg::*;

    logic               busy_reg;
    logic               fin_reg;
    logic               done_reg;
    logic               div_reg;
    logic               neg_reg;
    logic               nzero_reg;
    logic               dzero_reg;
    logic               ovf_reg;
    logic [6:0]         cnt_reg;
    logic [127:0]       work_reg;
    logic [63:0]        opb_reg;
    logic [63:0]        rem_reg;
    logic [63:0]        quo_reg;
    logic signed [63:0] result_reg;

    logic [63:0]  mag_a;
    logic [63:0]  mag_b;
    logic [64:0]  mul_sum;
    logic [64:0]  rem_shift;
    logic [64:0]  rem_diff;
    logic         rem_ge;
    logic [63:0]  fin_mag;
    logic         fin_ovf;
    logic [63:0]  fin_clamp;

    assign mag_a = op_a[63] ? 64'd0 - 64'(op_a) : 64'(op_a);
    assign mag_b = op_b[63] ? 64'd0 - 64'(op_b) : 64'(op_b);

    assign mul_sum   = {1'b0, work_reg[127:64]} + (work_reg[0] ? {1'b0, opb_reg} : 65'd0);
    assign rem_shift = {rem_reg, work_reg[127]};
    assign rem_diff  = rem_shift - {1'b0, opb_reg};
    assign rem_ge    = rem_shift >= {1'b0, opb_reg};

    always_comb
    begin
        if (div_reg)
        begin
            fin_ovf = ovf_reg;
            fin_mag = quo_reg;
            // division by zero: zero over zero is zero, else full scale
            if (dzero_reg)
            begin
                fin_ovf = !nzero_reg;
                fin_mag = 64'd0;
            end
        end
        else
        begin
            fin_ovf = |work_reg[127:64+FRAC_BITS];
            fin_mag = work_reg[64+FRAC_BITS-1:FRAC_BITS];
        end
        if (fin_ovf || fin_mag[63])
            fin_clamp = 64'(S64_MAX);
        else
            fin_clamp = fin_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                div_reg   <= req.div;
                neg_reg   <= op_a[63] ^ op_b[63];
                nzero_reg <= (mag_a == 64'd0);
                dzero_reg <= (mag_b == 64'd0);
                ovf_reg   <= 1'b0;
                rem_reg   <= 64'd0;
                quo_reg   <= 64'd0;
                if (req.div)
                begin
                    work_reg <= {64'd0, mag_a} << FRAC_BITS;
                    opb_reg  <= mag_b;
                    cnt_reg  <= 7'd127;
                end
                else
                begin
                    work_reg <= {64'd0, mag_b};
                    opb_reg  <= mag_a;
                    cnt_reg  <= 7'd63;
                end
            end
            else if (busy_reg)
            begin
                if (div_reg)
                begin
                    rem_reg  <= rem_ge ? rem_diff[63:0] : rem_shift[63:0];
                    work_reg <= work_reg << 1;
                    ovf_reg  <= ovf_reg | quo_reg[63];
                    quo_reg  <= {quo_reg[62:0], rem_ge};
                end
                else
                begin
                    work_reg <= {mul_sum, work_reg[63:1]};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                result_reg <= neg_reg ? -$signed(fin_clamp) : $signed(fin_clamp);
                done_reg   <= 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign result   = result_reg;

endmodule

### dv/tb_top.sv
// tb_top: self-checking testbench for brent_root_finder, driving searches against
// software test functions and checking every result word. Depends on brf_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import brf_pkg::*;

    typedef logic signed [63:0] q_t;
    typedef enum logic [1:0] {ST_IDLE, ST_WAIT_FA, ST_WAIT_FB, ST_ITER} search_state_t;
    typedef struct {
        logic [2:0] outcome;
        q_t         point;
    } answer_t;

    localparam q_t QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam q_t QMIN = 64'sh8000_0000_0000_0000;
    localparam q_t QONE = 64'sh0000_0001_0000_0000;
    localparam longint CYCLE_LIMIT = 12_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = CFG_TOLERANCE;
    logic [62:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        opcode = OP_START;
    q_t          left_end = '0;
    q_t          right_end = '0;
    q_t          func_value = '0;
    logic        value_invalid = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  outcome;
    q_t          point;

    bit     quiet = 1'b0;
    longint cycles = 0;

    brent_root_finder DUT (.*);

    always #4 clk = ~clk;

    // saturating fixed-point arithmetic
    function automatic q_t sadd(q_t x, q_t y);
        logic signed [64:0] s;
        s = {x[63], x} + {y[63], y};
        if (s[64] != s[63]) return s[64] ? QMIN : QMAX;
        return s[63:0];
    endfunction

    function automatic q_t ssub(q_t x, q_t y);
        logic signed [64:0] s;
        s = {x[63], x} - {y[63], y};
        if (s[64] != s[63]) return s[64] ? QMIN : QMAX;
        return s[63:0];
    endfunction

    function automatic q_t sneg(q_t x);
        return (x == QMIN) ? QMAX : -x;
    endfunction

    function automatic q_t sabs(q_t x);
        return (x < 0) ? sneg(x) : x;
    endfunction

    function automatic q_t halve(q_t x);
        return x / 64'sd2;
    endfunction

    function automatic logic [63:0] magnitude(q_t x);
        return (x < 0) ? 64'd0 - 64'(x) : 64'(x);
    endfunction

    function automatic q_t signed_clip(logic [127:0] m, bit neg);
        logic [63:0] v;
        v = (m[127:64] != 0) ? '1 : m[63:0];
        if (v > 64'(QMAX)) v = 64'(QMAX);
        return neg ? -q_t'(v) : q_t'(v);
    endfunction

    function automatic q_t qmul(q_t x, q_t y);
        logic [127:0] prod;
        prod = {64'd0, magnitude(x)} * {64'd0, magnitude(y)};
        return signed_clip(prod >> 32, (x < 0) != (y < 0));
    endfunction

    function automatic q_t qdiv(q_t x, q_t y);
        logic [127:0] quo;
        if (y == 0) return (x == 0) ? 64'sd0 : ((x > 0) ? QMAX : -QMAX);
        quo = ({64'd0, magnitude(x)} << 32) / {64'd0, magnitude(y)};
        return signed_clip(quo, (x < 0) != (y < 0));
    endfunction

    function automatic bit signs_differ(q_t x, q_t y);
        return (x > 0 && y < 0) || (x < 0 && y > 0);
    endfunction

    function automatic int gap_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 90);
    endfunction

    function automatic q_t rand_q();
        return q_t'({$urandom, $urandom});
    endfunction

    class root_scoreboard;
        logic [62:0]   tol;
        logic [15:0]   iter_limit;
        logic [31:0]   rel_eps;
        search_state_t st;
        q_t            pa, pb, pc, va, vb, vc, sd, se;
        logic [15:0]   iters;
        answer_t       pending[$];
        logic [2:0]    last_outcome;
        q_t            last_point;
        int            errors;

        function new();
            tol = 63'd4295;
            iter_limit = 16'd100;
            rel_eps = '0;
            st = ST_IDLE;
            {pa, pb, pc, va, vb, vc, sd, se} = '0;
            iters = '0;
            errors = 0;
            last_outcome = OUT_BADARG;
            last_point = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [62:0] data);
            if (idx == CFG_TOLERANCE) tol = data;
            else if (idx == CFG_ITER_LIMIT) iter_limit = data[15:0];
            else if (idx == CFG_REL_EPS) rel_eps = data[31:0];
        endfunction

        // one brent step with vb holding f(pb)
        function void brent_step(output logic [2:0] oc, output q_t pt);
            q_t t, tol1, xm, xm2, eps_q, s, p, q, qq, r, rm1, m1, m2;
            if (!signs_differ(vb, vc)) begin
                pc = pa; vc = va;
                sd = ssub(pb, pa); se = sd;
            end
            if (sabs(vc) < sabs(vb)) begin
                pa = pb; pb = pc; pc = pa;
                va = vb; vb = vc; vc = va;
            end
            eps_q = {32'd0, rel_eps};
            t = sabs(pb);
            tol1 = sadd(qmul(eps_q, sadd(t, t)), halve({1'b0, tol}));
            xm = halve(ssub(pc, pb));
            if (sabs(xm) <= tol1 || vb == 0) begin
                oc = OUT_FOUND;
                pt = pb;
                return;
            end
            xm2 = sadd(xm, xm);
            if (sabs(se) >= tol1 && sabs(va) > sabs(vb)) begin
                s = qdiv(vb, va);
                if (pa == pc) begin
                    p = qmul(xm2, s);
                    q = ssub(QONE, s);
                end
                else begin
                    qq = qdiv(va, vc);
                    r = qdiv(vb, vc);
                    rm1 = ssub(r, QONE);
                    p = qmul(s, ssub(qmul(qmul(xm2, qq), ssub(qq, r)),
                                     qmul(ssub(pb, pa), rm1)));
                    q = qmul(qmul(ssub(qq, QONE), rm1), ssub(s, QONE));
                end
                if (p > 0) q = sneg(q);
                p = sabs(p);
                m1 = ssub(qmul(sadd(xm2, xm), q), sabs(qmul(tol1, q)));
                m2 = sabs(qmul(se, q));
                if (sadd(p, p) < ((m1 < m2) ? m1 : m2)) begin
                    se = sd;
                    sd = qdiv(p, q);
                end
                else begin
                    sd = xm; se = xm;
                end
            end
            else begin
                sd = xm; se = xm;
            end
            pa = pb;
            va = vb;
            pb = sadd(pb, (sabs(sd) > tol1) ? sd : ((xm > 0) ? tol1 : sneg(tol1)));
            st = ST_ITER;
            oc = OUT_EVAL;
            pt = pb;
        endfunction

        function void note_input(logic op, q_t le, q_t re, q_t fv, logic inv);
            answer_t a;
            a.outcome = OUT_EVAL;
            a.point = '0;
            if (op == OP_START) begin
                if (tol == 0 || iter_limit == 0) begin
                    a.outcome = OUT_BADARG;
                end
                else begin
                    pa = le; pb = re;
                    iters = '0;
                    st = ST_WAIT_FA;
                    a.point = pa;
                end
            end
            else if (st == ST_IDLE) begin
                a.outcome = OUT_UNEXP;
            end
            else if (inv) begin
                a.outcome = OUT_NOCONV;
            end
            else if (st == ST_WAIT_FA) begin
                va = fv;
                st = ST_WAIT_FB;
                a.point = pb;
            end
            else begin
                vb = fv;
                if (st == ST_WAIT_FB) begin
                    if (va == 0) begin
                        a.outcome = OUT_FOUND; a.point = pa;
                    end
                    else if (vb == 0) begin
                        a.outcome = OUT_FOUND; a.point = pb;
                    end
                    else if (!signs_differ(va, vb)) begin
                        a.outcome = OUT_NOCONV;
                    end
                    else begin
                        pc = pa; vc = va;
                        sd = ssub(pb, pa); se = sd;
                        iters = '0;
                        brent_step(a.outcome, a.point);
                    end
                end
                else begin
                    iters = iters + 16'd1;
                    if (iters >= iter_limit || iters == 0) a.outcome = OUT_NOCONV;
                    else brent_step(a.outcome, a.point);
                end
            end
            if (a.outcome != OUT_EVAL) st = ST_IDLE;
            pending.push_back(a);
            last_outcome = a.outcome;
            last_point = a.point;
        endfunction

        function void check_result(logic [2:0] oc, q_t pt);
            answer_t a;
            if (pending.size() == 0) begin
                $error("result word with nothing expected: outcome %0d point %h", oc, pt);
                errors++;
                return;
            end
            a = pending.pop_front();
            if (oc !== a.outcome) begin
                $error("outcome: expected %0d, actual %0d", a.outcome, oc);
                errors++;
            end
            if (pt !== a.point) begin
                $error("point: expected %h, actual %h", a.point, pt);
                errors++;
            end
        endfunction
    endclass

    root_scoreboard sb = new();

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[brent_root_finder] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(outcome, point);

    // receiver stalls
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                out_ready <= 1'b0;
                stall--;
            end
            else begin
                out_ready <= 1'b1;
                stall = gap_len();
            end
        end
    end

    task automatic send_word(logic op, q_t le, q_t re, q_t fv, logic inv);
        int g;
        g = gap_len();
        @(negedge clk);
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        left_end <= le;
        right_end <= re;
        func_value <= fv;
        value_invalid <= inv;
        do @(posedge clk); while (!in_ready);
        sb.note_input(op, le, re, fv, inv);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [62:0] data);
        @(negedge clk);
        in_valid <= 1'b0;
        drain();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // test function: slope*d + curve*d^3 around a root
    function automatic q_t eval_func(q_t x, q_t root, q_t slope, q_t curve);
        q_t d;
        d = ssub(x, root);
        return sadd(qmul(slope, d), qmul(curve, qmul(d, qmul(d, d))));
    endfunction

    // answers requests until the search ends or is cut off
    task automatic run_search(q_t le, q_t re, q_t root, q_t slope, q_t curve,
                              int cut_pct, ref int sent);
        int n;
        send_word(OP_START, le, re, rand_q(), 1'($urandom_range(0, 1)));
        sent++;
        n = 0;
        while (sb.last_outcome == OUT_EVAL && n < 300) begin
            if ($urandom_range(0, 999) < cut_pct) return;
            if ($urandom_range(0, 199) == 0)
                send_word(OP_VALUE, rand_q(), rand_q(), rand_q(), 1'b1);
            else
                send_word(OP_VALUE, rand_q(), rand_q(),
                          eval_func(sb.last_point, root, slope, curve), 1'b0);
            sent++;
            n++;
        end
    endtask

    task automatic random_search(ref int sent);
        q_t root, slope, curve, lo, hi;
        root = q_t'($signed({$urandom, $urandom}) >>> $urandom_range(20, 30));
        slope = q_t'(64'($urandom_range(1, 32'hFFFF)) << $urandom_range(16, 36));
        curve = ($urandom_range(0, 1)) ? q_t'(64'($urandom_range(0, 32'hFFFF)) << 8) : 64'sd0;
        if ($urandom_range(0, 1)) begin
            slope = -slope;
            curve = -curve;
        end
        lo = ssub(root, q_t'(64'($urandom_range(1, 32'hFFFF_FFFF)) << $urandom_range(0, 10)));
        hi = sadd(root, q_t'(64'($urandom_range(1, 32'hFFFF_FFFF)) << $urandom_range(0, 10)));
        if ($urandom_range(0, 1)) run_search(lo, hi, root, slope, curve, 3, sent);
        else run_search(hi, lo, root, slope, curve, 3, sent);
    endtask

    initial begin
        int sent, pick;
        q_t r;
        sent = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: odd words, bracket end cases, extremes
        send_word(OP_VALUE, QMAX, QMIN, QMAX, 1'b0);
        send_word(OP_START, QMIN, QMAX, '0, 1'b0);
        send_word(OP_VALUE, '0, '0, QMIN, 1'b0);
        send_word(OP_VALUE, '0, '0, QMAX, 1'b0);
        send_word(OP_START, 64'sd5 <<< 32, 64'sd9 <<< 32, '0, 1'b0);
        send_word(OP_VALUE, '0, '0, '0, 1'b0);
        send_word(OP_VALUE, '0, '0, 64'sd7, 1'b0);
        send_word(OP_START, -64'sd3 <<< 32, 64'sd2 <<< 32, '0, 1'b0);
        send_word(OP_VALUE, '0, '0, -64'sd1, 1'b0);
        send_word(OP_VALUE, '0, '0, '0, 1'b0);
        send_word(OP_START, QMAX, QMIN, '0, 1'b0);
        send_word(OP_VALUE, '0, '0, 64'sd4, 1'b0);
        send_word(OP_VALUE, '0, '0, 64'sd9, 1'b0);
        send_word(OP_START, 64'sd1, -64'sd1, '0, 1'b0);
        send_word(OP_VALUE, '0, '0, '0, 1'b1);
        send_word(OP_START, 64'sd1, 64'sd2, '0, 1'b0);
        send_word(OP_START, -64'sd2 <<< 32, 64'sd3 <<< 32, '0, 1'b0);
        r = 64'sd1 <<< 31;
        run_search(-64'sd2 <<< 32, 64'sd3 <<< 32, r, QONE, '0, 0, sent);
        write_cfg(CFG_TOLERANCE, '0);
        send_word(OP_START, QONE, -QONE, '0, 1'b0);
        write_cfg(CFG_TOLERANCE, 63'd4295);
        write_cfg(CFG_ITER_LIMIT, '0);
        send_word(OP_START, QONE, -QONE, '0, 1'b0);
        write_cfg(CFG_ITER_LIMIT, 63'd1);
        run_search(-QONE, QONE <<< 4, r, QONE, '0, 0, sent);
        write_cfg(CFG_ITER_LIMIT, 63'd100);
        write_cfg(CFG_REL_EPS, 63'hFFFF_FFFF);
        run_search(-QONE, QONE <<< 4, r, -QONE, '0, 0, sent);
        write_cfg(CFG_REL_EPS, '0);

        sent = 0;
        while (sent < 1650) begin
            if ($urandom_range(0, 29) == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 9);
                case (pick)
                    0: write_cfg(CFG_TOLERANCE, 63'({$urandom, $urandom}));
                    1: write_cfg(CFG_TOLERANCE, '1);
                    2: write_cfg(CFG_TOLERANCE, 63'd1);
                    3: write_cfg(CFG_TOLERANCE, 63'($urandom_range(1, 32'h00FF_FFFF)));
                    4: write_cfg(CFG_ITER_LIMIT, 63'($urandom_range(1, 60)));
                    5: write_cfg(CFG_ITER_LIMIT, 63'd65535);
                    6: write_cfg(CFG_ITER_LIMIT, 63'($urandom_range(0, 3)));
                    7: write_cfg(CFG_REL_EPS, 63'($urandom));
                    8: write_cfg(CFG_REL_EPS, '0);
                    default: write_cfg(CFG_REL_EPS, 63'($urandom_range(0, 32'hFFFF)));
                endcase
                if (sb.tol == 0 && $urandom_range(0, 1)) write_cfg(CFG_TOLERANCE, 63'd4295);
                if (sb.iter_limit == 0 && $urandom_range(0, 1))
                    write_cfg(CFG_ITER_LIMIT, 63'd40);
            end
            pick = $urandom_range(0, 99);
            if (pick < 82) begin
                random_search(sent);
            end
            else if (pick < 90) begin
                // garbage bracket and values
                send_word(OP_START, rand_q(), rand_q(), rand_q(), 1'($urandom_range(0, 1)));
                sent++;
                repeat ($urandom_range(1, 4)) begin
                    send_word(OP_VALUE, rand_q(), rand_q(), rand_q(),
                              $urandom_range(0, 7) == 0);
                    sent++;
                end
            end
            else if (pick < 95) begin
                send_word(OP_VALUE, rand_q(), rand_q(), rand_q(), 1'($urandom_range(0, 1)));
                sent++;
            end
            else begin
                // bracket end lands on the root, or same sign at both ends
                r = rand_q() >>> 24;
                if ($urandom_range(0, 1))
                    run_search(r, sadd(r, QONE), r, QONE, '0, 0, sent);
                else
                    run_search(sadd(r, QONE), sadd(r, QONE <<< 1), r, QONE, '0, 0, sent);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        drain();
        repeat (1500) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[brent_root_finder] OK");
        else
            $display("[brent_root_finder] ERROR");
        $finish;
    end

endmodule

### filelist.f
src/brf_pkg.sv
src/brf_muldiv.sv
src/brent_root_finder.sv
dv/tb_top.sv
